@@ design/mgm_pkg.sv @@
// mgm_pkg: shared constants and types for the muted gain mixer
// register indexes, fixed field widths and the divider control struct
// no dependencies
package mgm_pkg;

  localparam int GAIN_BITS      = 16;
  localparam int OFFSET_BITS    = 15;
  localparam int THRESH_BITS    = 16;
  localparam int MIX_SHIFT      = 14;
  localparam int LANES_MAX      = 4;
  localparam int DIV_STEP_BITS  = 8;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_ADDR_BITS  = 6;

  localparam logic [2:0] REG_GAINS_G0   = 3'd0;
  localparam logic [2:0] REG_GAINS_G1   = 3'd1;
  localparam logic [2:0] REG_AVG_EN     = 3'd2;
  localparam logic [2:0] REG_OFFSET_G0  = 3'd3;
  localparam logic [2:0] REG_OFFSET_G1  = 3'd4;
  localparam logic [2:0] REG_HOLD_HIGH  = 3'd5;
  localparam logic [2:0] REG_HOLD_LOW   = 3'd6;

  localparam logic signed [THRESH_BITS-1:0] HOLD_HIGH_RST = 16'sd2048;
  localparam logic signed [THRESH_BITS-1:0] HOLD_LOW_RST  = 16'sd102;

  typedef struct packed {
    logic       start;
    logic [2:0] divisor;
  } mgm_div_ctl_t;

endpackage

@@ design/mgm_lane.sv @@
// mgm_lane: one mixer channel, gated sample times gain, registered
// depends on mgm_pkg
module mgm_lane import mgm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    load_i,
  input  logic                                    enable_i,
  input  logic signed [SAMPLE_BITS-1:0]           sample_i,
  input  logic signed [GAIN_BITS-1:0]             gain_i,
  output logic signed [SAMPLE_BITS+GAIN_BITS-1:0] prod_o
);

  logic signed [SAMPLE_BITS+GAIN_BITS-1:0] prod_d, prod_q;

  always_comb begin
    if (enable_i) begin
      prod_d = (SAMPLE_BITS+GAIN_BITS)'(sample_i) * (SAMPLE_BITS+GAIN_BITS)'(gain_i);
    end else begin
      prod_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ design/mgm_merge.sv @@
// mgm_merge: sums the lane products and counts the mixed channels
// depends on mgm_pkg
module mgm_merge import mgm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int LANES       = 4
) (
  input  logic                                    clk_i,
  input  logic                                    load_i,
  input  logic signed [SAMPLE_BITS+GAIN_BITS-1:0] prod_i [LANES],
  input  logic [LANES-1:0]                        enable_i,
  output logic signed [SAMPLE_BITS+GAIN_BITS+1:0] sum_o,
  output logic [2:0]                              count_o
);

  localparam int ACC_W = SAMPLE_BITS + GAIN_BITS + 2;

  logic signed [ACC_W-1:0] sum_d, sum_q;
  logic [2:0]              count_d, count_q;

  always_comb begin
    sum_d   = '0;
    count_d = '0;
    for (int j = 0; j < LANES; j++) begin
      sum_d   = sum_d + ACC_W'(prod_i[j]);
      count_d = count_d + 3'(enable_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = count_q;

endmodule

@@ design/mgm_div.sv @@
// mgm_div: signed divide by a small count, truncating toward zero
// radix-2 restoring, several quotient bits per cycle; depends on mgm_pkg
module mgm_div import mgm_pkg::*; #(
  parameter int W = 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mgm_div_ctl_t        ctl_i,
  input  logic signed [W-1:0] dividend_i,
  output logic                busy_o,
  output logic signed [W-1:0] quotient_o
);

  localparam int NSTEP = (W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PW    = NSTEP * DIV_STEP_BITS;
  localparam int CNT_W = $clog2(NSTEP + 1);

  logic [PW-1:0]    work_d, work_q;
  logic [1:0]       rem_d, rem_q;
  logic [2:0]       div_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     mag;

  assign mag = dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);

  always_comb begin
    logic [PW-1:0] w;
    logic [2:0]    r;
    w = work_q;
    r = {1'b0, rem_q};
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      r = {r[1:0], w[PW-1]};
      w = {w[PW-2:0], 1'b0};
      if (r >= div_q) begin
        r    = r - div_q;
        w[0] = 1'b1;
      end
    end
    work_d = w;
    rem_d  = r[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.start) begin
      cnt_q <= CNT_W'(NSTEP);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      work_q <= PW'(mag);
      rem_q  <= '0;
      div_q  <= ctl_i.divisor;
      neg_q  <= dividend_i[W-1];
    end else if (cnt_q != '0) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = neg_q ? -$signed(work_q[W-1:0]) : $signed(work_q[W-1:0]);

endmodule

@@ design/muted_gain_mixer_with_sample_hold_top.sv @@
// muted_gain_mixer_with_sample_hold_top: mixer lanes, merge, divider, hold
// depends on mgm_pkg, mgm_lane, mgm_merge, mgm_div
//
//   port group   | direction | handshake
//   -------------+-----------+------------------------------------------
//   input item   | in        | in_valid_i / in_ready_o
//   result item  | out       | out_valid_o / out_ready_i
//   config       | in/out    | apb psel/penable/pwrite, pready tied high
//
// one item at a time: S_MUL, S_SUM, S_LOAD, then S_DIV until the serial count divider,
// with NSTEP = ceil((SAMPLE_BITS+18)/8) steps, is done and the output register is free
// the output register lets the next item in while a result waits
// that next item then stalls at the hold stage, and input waits until the result leaves
// reset: all channels active, buttons treated as pressed, trigger high, held zero
module muted_gain_mixer_with_sample_hold_top import mgm_pkg::*; #(
  parameter int CHANNELS_PER_GROUP = 4,
  parameter int GROUP_COUNT        = 2,
  parameter int SAMPLE_BITS        = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_BITS-1:0]      paddr,
  input  logic [CFG_DATA_BITS-1:0]      pwdata,
  output logic [CFG_DATA_BITS-1:0]      prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          group_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_zero_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_one_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_two_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_three_i,
  input  logic [3:0]                    connected_mask_i,
  input  logic [3:0]                    button_levels_i,
  input  logic signed [SAMPLE_BITS-1:0] hold_trigger_i,
  input  logic                          hold_connected_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_group_o,
  output logic signed [SAMPLE_BITS-1:0] mix_out_o,
  output logic [3:0]                    active_mask_o
);

  localparam int NL     = (CHANNELS_PER_GROUP < LANES_MAX) ? CHANNELS_PER_GROUP : LANES_MAX;
  localparam int GIDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int PROD_W = SAMPLE_BITS + GAIN_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SHR_W  = ACC_W - MIX_SHIFT;
  localparam int MIX_W  = SAMPLE_BITS + 5;
  localparam int CMP_W  = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
  localparam logic [3:0] LMASK = 4'((1 << NL) - 1);
  localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MIX_W-1:0] SAT_LO = MIX_W'(-(1 << (SAMPLE_BITS - 1)));

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUM  = 5'b00100,
    S_LOAD = 5'b01000,
    S_DIV  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CFG_DATA_BITS-1:0]      gains0_q, gains1_q;
  logic [1:0]                    avg_q;
  logic signed [OFFSET_BITS-1:0] off0_q, off1_q;
  logic signed [THRESH_BITS-1:0] hth_q, lth_q;
  logic                          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains0_q <= '0;
      gains1_q <= '0;
      avg_q    <= '0;
      off0_q   <= '0;
      off1_q   <= '0;
      hth_q    <= HOLD_HIGH_RST;
      lth_q    <= HOLD_LOW_RST;
    end else if (cfg_we) begin
      case (paddr[5:3])
        REG_GAINS_G0:  gains0_q <= pwdata;
        REG_GAINS_G1:  gains1_q <= pwdata;
        REG_AVG_EN:    avg_q    <= pwdata[1:0];
        REG_OFFSET_G0: off0_q   <= $signed(pwdata[OFFSET_BITS-1:0]);
        REG_OFFSET_G1: off1_q   <= $signed(pwdata[OFFSET_BITS-1:0]);
        REG_HOLD_HIGH: hth_q    <= $signed(pwdata[THRESH_BITS-1:0]);
        REG_HOLD_LOW:  lth_q    <= $signed(pwdata[THRESH_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_GAINS_G0:  prdata = gains0_q;
      REG_GAINS_G1:  prdata = gains1_q;
      REG_AVG_EN:    prdata = CFG_DATA_BITS'(avg_q);
      REG_OFFSET_G0: prdata = CFG_DATA_BITS'($unsigned(off0_q));
      REG_OFFSET_G1: prdata = CFG_DATA_BITS'($unsigned(off1_q));
      REG_HOLD_HIGH: prdata = CFG_DATA_BITS'($unsigned(hth_q));
      REG_HOLD_LOW:  prdata = CFG_DATA_BITS'($unsigned(lth_q));
      default:       prdata = '0;
    endcase
  end

  // per-group state
  logic [3:0]                    act_q  [GROUP_COUNT];
  logic [3:0]                    btn_q  [GROUP_COUNT];
  logic [GROUP_COUNT-1:0]        trig_q;
  logic signed [SAMPLE_BITS-1:0] held_q [GROUP_COUNT];

  // item latched at accept
  logic [GIDX_W-1:0]             g_q;
  logic [NL-1:0]                 en_q;
  logic [3:0]                    amask_q;
  logic signed [SAMPLE_BITS-1:0] smp_q [NL];
  logic signed [SAMPLE_BITS-1:0] lvl_q;
  logic                          hconn_q;

  logic                          accept, finish, out_free;
  logic [GIDX_W-1:0]             g_in;
  logic [3:0]                    btn_m, new_act;
  logic signed [SAMPLE_BITS-1:0] smp_in [LANES_MAX];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign g_in       = (GROUP_COUNT > 1) ? GIDX_W'(group_i) : '0;
  assign btn_m      = button_levels_i & LMASK;
  // rising button edges toggle the active flags
  assign new_act    = act_q[g_in] ^ (btn_m & ~btn_q[g_in]);

  assign smp_in[0] = sample_zero_i;
  assign smp_in[1] = sample_one_i;
  assign smp_in[2] = sample_two_i;
  assign smp_in[3] = sample_three_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      g_q     <= g_in;
      en_q    <= NL'(new_act & connected_mask_i & LMASK);
      amask_q <= new_act;
      lvl_q   <= hold_trigger_i;
      hconn_q <= hold_connected_i;
      for (int j = 0; j < NL; j++) begin
        smp_q[j] <= smp_in[j];
      end
    end
  end

  // lanes
  logic [CFG_DATA_BITS-1:0] gsel;
  logic signed [PROD_W-1:0] prod [NL];

  assign gsel = g_q[0] ? gains1_q : gains0_q;

  for (genvar j = 0; j < NL; j++) begin : g_lane
    mgm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk_i    (clk_i),
      .load_i   (state_q == S_MUL),
      .enable_i (en_q[j]),
      .sample_i (smp_q[j]),
      .gain_i   ($signed(gsel[GAIN_BITS*j +: GAIN_BITS])),
      .prod_o   (prod[j])
    );
  end

  logic signed [ACC_W-1:0] sum;
  logic [2:0]              count;

  mgm_merge #(.SAMPLE_BITS(SAMPLE_BITS), .LANES(NL)) u_merge (
    .clk_i    (clk_i),
    .load_i   (state_q == S_SUM),
    .prod_i   (prod),
    .enable_i (en_q),
    .sum_o    (sum),
    .count_o  (count)
  );

  mgm_div_ctl_t            div_ctl;
  logic                    div_busy;
  logic signed [ACC_W-1:0] quot;

  // no averaging or nothing mixed: divide by one
  assign div_ctl.start   = (state_q == S_LOAD);
  assign div_ctl.divisor = (avg_q[g_q[0]] && count != '0) ? count : 3'd1;

  mgm_div #(.W(ACC_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (sum),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // floor shift, offset, saturate
  logic signed [SHR_W-1:0]       shr;
  logic signed [OFFSET_BITS-1:0] off_sel;
  logic signed [MIX_W-1:0]       mix_sum;
  logic signed [SAMPLE_BITS-1:0] mix_sat;

  assign shr     = $signed(quot[ACC_W-1:MIX_SHIFT]);
  assign off_sel = g_q[0] ? off1_q : off0_q;
  assign mix_sum = MIX_W'(shr) + MIX_W'(off_sel);

  always_comb begin
    if (mix_sum > SAT_HI) begin
      mix_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (mix_sum < SAT_LO) begin
      mix_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      mix_sat = mix_sum[SAMPLE_BITS-1:0];
    end
  end

  // schmitt trigger and hold
  logic signed [CMP_W-1:0]       lvl, hth, lth;
  logic                          trig_nx;
  logic signed [SAMPLE_BITS-1:0] held_nx;

  assign lvl = CMP_W'(lvl_q);
  assign hth = CMP_W'(hth_q);
  assign lth = CMP_W'(lth_q);

  always_comb begin
    trig_nx = trig_q[g_q];
    held_nx = held_q[g_q];
    if (hconn_q) begin
      if (trig_q[g_q]) begin
        if (lvl <= lth) begin
          trig_nx = 1'b0;
        end
      end else if (lvl >= hth) begin
        trig_nx = 1'b1;
        held_nx = mix_sat;
      end
    end else begin
      held_nx = mix_sat;
    end
  end

  logic out_valid_q;
  assign out_free = ~out_valid_q | out_ready_i;
  assign finish   = (state_q == S_DIV) & ~div_busy & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        act_q[g]  <= LMASK;
        btn_q[g]  <= LMASK;
        held_q[g] <= '0;
      end
      trig_q <= '1;
    end else begin
      if (accept) begin
        act_q[g_in] <= new_act;
        btn_q[g_in] <= btn_m;
      end
      if (finish) begin
        trig_q[g_q] <= trig_nx;
        held_q[g_q] <= held_nx;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_MUL;
      end
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = S_LOAD;
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (finish) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic                          out_group_q;
  logic signed [SAMPLE_BITS-1:0] out_mix_q;
  logic [3:0]                    out_act_q;

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_group_q <= g_q[0];
      out_mix_q   <= held_nx;
      out_act_q   <= amask_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_group_o   = out_group_q;
  assign mix_out_o     = out_mix_q;
  assign active_mask_o = out_act_q;

endmodule

@@ design/mgm_checker.sv @@
// mgm_checker: port-level assertions for the mixer top level
// bound to muted_gain_mixer_with_sample_hold_top; depends on nothing else
module mgm_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   pready,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   out_group_o,
  input logic [SAMPLE_BITS-1:0] mix_out_o,
  input logic [3:0]             active_mask_o
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(mix_out_o)
      && $stable(out_group_o) && $stable(active_mask_o)))
    else $error("stalled result changed");

  // one item in flight: an accepted item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a new result comes out as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (in_ready_o && $past(!in_ready_o)))
    else $error("result appeared outside the finish step");

endmodule

bind muted_gain_mixer_with_sample_hold_top mgm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mgm_checker (.*);

@@ dv/muted_gain_mixer_with_sample_hold_top_tb.sv @@
// muted_gain_mixer_with_sample_hold_top_tb: self-checking bench for the two-group gain mixer
// drives frames and apb register writes, predicts every result item and checks it in order
// depends on mgm_pkg and muted_gain_mixer_with_sample_hold_top
module muted_gain_mixer_with_sample_hold_top_tb import mgm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB              = 16;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int PHASES          = 6;
  localparam int HOLD_CYCLES     = 400;
  localparam int WD_LIMIT        = 4000;
  localparam int END_WAIT        = 30;

  typedef struct packed {
    logic             grp;
    logic [3:0][SB-1:0] smp;
    logic [3:0]       conn;
    logic [3:0]       btn;
    logic [SB-1:0]    trig;
    logic             hold_conn;
  } frame_t;

  typedef struct packed {
    logic          grp;
    logic [SB-1:0] mix;
    logic [3:0]    act;
  } mix_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [63:0] reg_val;
    frame_t      frm;
    bit          typed;
    mix_result_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  frame_t      in_frame = '0;
  bit          in_typed = 1'b0;
  mix_result_t in_want = '0;

  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic          out_group_o;
  logic [SB-1:0] mix_out_o;
  logic [3:0]    active_mask_o;

  // register mirror
  logic [63:0]         cfg_gain [2] = '{64'd0, 64'd0};
  logic [1:0]          cfg_avg = 2'd0;
  logic signed [14:0]  cfg_offset [2] = '{15'sd0, 15'sd0};
  logic signed [15:0]  cfg_high = HOLD_HIGH_RST;
  logic signed [15:0]  cfg_low = HOLD_LOW_RST;

  // mixer state mirror
  logic [3:0]    chan_on [2] = '{4'hF, 4'hF};
  logic [3:0]    btn_prev [2] = '{4'hF, 4'hF};
  bit            trig_hi [2] = '{1'b1, 1'b1};
  logic [SB-1:0] held [2] = '{'0, '0};

  mix_result_t pending_mix [$];
  row_t        stim_rows [$];

  int n_sent = 0;
  int n_done = 0;
  int n_err = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  muted_gain_mixer_with_sample_hold_top #(
    .CHANNELS_PER_GROUP(4),
    .GROUP_COUNT(2),
    .SAMPLE_BITS(SB)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .group_i(in_frame.grp),
    .sample_zero_i(in_frame.smp[0]),
    .sample_one_i(in_frame.smp[1]),
    .sample_two_i(in_frame.smp[2]),
    .sample_three_i(in_frame.smp[3]),
    .connected_mask_i(in_frame.conn),
    .button_levels_i(in_frame.btn),
    .hold_trigger_i(in_frame.trig),
    .hold_connected_i(in_frame.hold_conn),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_group_o(out_group_o),
    .mix_out_o(mix_out_o),
    .active_mask_o(active_mask_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [SB-1:0] clamp16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SB-1:0];
  endfunction

  // toggles, weighted sum, optional average, offset, saturation, then sample and hold
  function automatic mix_result_t mix_frame(frame_t f);
    longint      acc;
    longint      mix;
    longint      lvl;
    int          count;
    int          g;
    logic [63:0] gains;
    logic [3:0]  live;
    g = f.grp;
    gains = cfg_gain[g];
    chan_on[g] = chan_on[g] ^ (f.btn & ~btn_prev[g]);
    btn_prev[g] = f.btn;
    live = chan_on[g] & f.conn;
    acc = 0;
    count = 0;
    for (int j = 0; j < 4; j++) begin
      if (live[j]) begin
        acc += longint'($signed(f.smp[j])) * longint'($signed(gains[16*j +: 16]));
        count++;
      end
    end
    if (count > 0 && cfg_avg[g]) acc = acc / count;
    // arithmetic shift floors, matching the q20.14 to q20.0 step
    mix = (acc >>> 14) + longint'(cfg_offset[g]);
    if (mix > 32767) mix = 32767;
    if (mix < -32768) mix = -32768;
    if (f.hold_conn) begin
      lvl = longint'($signed(f.trig));
      if (trig_hi[g]) begin
        if (lvl <= longint'(cfg_low)) trig_hi[g] = 1'b0;
      end else if (lvl >= longint'(cfg_high)) begin
        trig_hi[g] = 1'b1;
        held[g] = mix[SB-1:0];
      end
    end else begin
      held[g] = mix[SB-1:0];
    end
    return '{grp: f.grp, mix: held[g], act: chan_on[g]};
  endfunction

  function automatic frame_t mk_frame(bit grp, int s0, int s1, int s2, int s3,
                                      int conn, int btn, int trig, bit hc);
    frame_t f;
    f.grp = grp;
    f.smp[0] = s0[SB-1:0];
    f.smp[1] = s1[SB-1:0];
    f.smp[2] = s2[SB-1:0];
    f.smp[3] = s3[SB-1:0];
    f.conn = conn[3:0];
    f.btn = btn[3:0];
    f.trig = trig[SB-1:0];
    f.hold_conn = hc;
    return f;
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    f.grp = 1'($urandom_range(1));
    for (int j = 0; j < 4; j++)
      f.smp[j] = roll(12) ? (roll(50) ? 16'h7FFF : 16'h8000) : 16'($urandom);
    f.conn = 4'($urandom_range(15));
    f.btn = 4'($urandom_range(15));
    f.hold_conn = roll(70);
    case ($urandom_range(3))
      0: f.trig = 16'($urandom);
      1: f.trig = clamp16(int'(cfg_high) + int'($urandom_range(64)));
      2: f.trig = clamp16(int'(cfg_low) - int'($urandom_range(64)));
      default: f.trig = clamp16((int'(cfg_high) + int'(cfg_low)) / 2);
    endcase
    return f;
  endfunction

  function automatic void add_item(frame_t f);
    row_t r;
    r.kind = ROW_ITEM;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.frm = f;
    r.typed = 1'b0;
    r.want = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_checked(frame_t f, bit grp, int mix, int act);
    row_t r;
    r.kind = ROW_ITEM;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.frm = f;
    r.typed = 1'b1;
    r.want = '{grp: grp, mix: mix[SB-1:0], act: act[3:0]};
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [63:0] val);
    row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.frm = '0;
    r.typed = 1'b0;
    r.want = '0;
    stim_rows.push_back(r);
  endfunction

  task automatic send_frame(frame_t f, bit typed, mix_result_t want);
    if (roll(tx_idle_pct)) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (roll(tx_idle_pct));
    end
    in_valid_i <= 1'b1;
    in_frame <= f;
    in_typed <= typed;
    in_want <= want;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (n_done != n_sent) @(posedge clk_i);
  endtask

  // leaves psel high so back-to-back writes go straight to the next setup cycle
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apb_idle();
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checker, input predictor and register mirror
  always @(posedge clk_i) begin : scoreboard
    mix_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_done++;
        if (pending_mix.size() == 0) begin
          $error("unexpected result item, group %0d mix %0d", out_group_o,
                 $signed(mix_out_o));
          n_err++;
        end else begin
          want = pending_mix.pop_front();
          if (out_group_o !== want.grp) begin
            $error("out_group: expected %0d, got %0d", want.grp, out_group_o);
            n_err++;
          end
          if (mix_out_o !== want.mix) begin
            $error("mix_out: expected %0d, got %0d", $signed(want.mix), $signed(mix_out_o));
            n_err++;
          end
          if (active_mask_o !== want.act) begin
            $error("active_mask: expected %h, got %h", want.act, active_mask_o);
            n_err++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = mix_frame(in_frame);
        pending_mix.push_back(in_typed ? in_want : want);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_GAINS_G0:  cfg_gain[0] = pwdata;
          REG_GAINS_G1:  cfg_gain[1] = pwdata;
          REG_AVG_EN:    cfg_avg = pwdata[1:0];
          REG_OFFSET_G0: cfg_offset[0] = pwdata[14:0];
          REG_OFFSET_G1: cfg_offset[1] = pwdata[14:0];
          REG_HOLD_HIGH: cfg_high = pwdata[15:0];
          REG_HOLD_LOW:  cfg_low = pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !roll(rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int off0;
    int off1;
    int hi;
    int lo;

    // reset defaults: zero gains give zero mix, buttons walk the toggle logic
    add_checked(mk_frame(0, 32767, 32767, 32767, 32767, 15, 15, 0, 0), 0, 0, 4'hF);
    add_checked(mk_frame(1, 32767, 32767, 32767, 32767, 15, 15, 0, 0), 1, 0, 4'hF);
    add_checked(mk_frame(0, 1, 2, 3, 4, 15, 0, 0, 0), 0, 0, 4'hF);
    add_checked(mk_frame(0, 1, 2, 3, 4, 15, 1, 0, 0), 0, 0, 4'hE);
    add_checked(mk_frame(0, 1, 2, 3, 4, 15, 15, 0, 0), 0, 0, 4'h0);
    add_checked(mk_frame(0, 1, 2, 3, 4, 15, 0, 0, 0), 0, 0, 4'h0);
    add_checked(mk_frame(0, 1, 2, 3, 4, 15, 15, 0, 0), 0, 0, 4'hF);
    // extreme gains and offsets saturate both ways
    add_cfg(REG_GAINS_G0, 64'h7FFF7FFF7FFF7FFF);
    add_cfg(REG_GAINS_G1, 64'h8000800080008000);
    add_cfg(REG_OFFSET_G0, 64'(10240));
    add_cfg(REG_OFFSET_G1, 64'(-10240));
    add_checked(mk_frame(0, 32767, 32767, 32767, 32767, 15, 15, 0, 0), 0, 32767, 4'hF);
    add_checked(mk_frame(0, -32768, -32768, -32768, -32768, 15, 15, 0, 0), 0, -32768, 4'hF);
    add_checked(mk_frame(1, -32768, -32768, -32768, -32768, 15, 15, 0, 0), 1, 32767, 4'hF);
    add_checked(mk_frame(1, 32767, 32767, 32767, 32767, 15, 15, 0, 0), 1, -32768, 4'hF);
    // nothing connected: only the offset is left
    add_checked(mk_frame(0, 32767, 32767, 32767, 32767, 0, 15, 0, 0), 0, 10240, 4'hF);
    add_checked(mk_frame(1, 32767, 32767, 32767, 32767, 0, 15, 0, 0), 1, -10240, 4'hF);
    // averaging, truncation toward zero, zero count
    add_cfg(REG_AVG_EN, 64'd3);
    add_cfg(REG_GAINS_G0, 64'h4000400040004000);
    add_cfg(REG_GAINS_G1, 64'h0001200_0C0004000);
    add_cfg(REG_OFFSET_G0, 64'd0);
    add_cfg(REG_OFFSET_G1, 64'(-1));
    add_item(mk_frame(0, -3, 0, 0, 0, 1, 15, 0, 0));
    add_item(mk_frame(0, -3, -2, 5, 1, 7, 15, 0, 0));
    add_item(mk_frame(1, 1000, -2000, 3000, -4000, 15, 15, 0, 0));
    add_item(mk_frame(1, 1000, -2000, 3000, -4000, 0, 15, 0, 0));
    add_item(mk_frame(0, -1, 7, -9, 11, 11, 4, 0, 0));
    // schmitt trigger: hold, fall, rise and sample, stay high, release
    add_cfg(REG_AVG_EN, 64'd1);
    add_cfg(REG_HOLD_HIGH, 64'd2048);
    add_cfg(REG_HOLD_LOW, 64'd102);
    add_item(mk_frame(0, 2000, 300, -50, 7, 15, 15, 2048, 1));
    add_item(mk_frame(0, 2100, 300, -50, 7, 15, 15, 102, 1));
    add_item(mk_frame(0, 2200, 300, -50, 7, 15, 15, 2047, 1));
    add_item(mk_frame(0, 2300, 300, -50, 7, 15, 15, 2048, 1));
    add_item(mk_frame(0, 2400, 300, -50, 7, 15, 15, 5000, 1));
    add_item(mk_frame(0, 2500, 300, -50, 7, 15, 15, 5000, 0));
    add_item(mk_frame(1, 2600, -300, 50, -7, 15, 15, -32768, 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        if (psel) apb_idle();
        send_frame(stim_rows[i].frm, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        1: begin tx_idle_pct = 63; rx_idle_pct = 0; end
        2: begin tx_idle_pct = 0; rx_idle_pct = 63; end
        3: begin tx_idle_pct = 10; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      off0 = int'($urandom_range(20480)) - 10240;
      off1 = int'($urandom_range(20480)) - 10240;
      hi = int'($urandom_range(8192)) - 2048;
      lo = hi - int'($urandom_range(4096));
      // opposite threshold extremes: always toggling, and rising only at 32767, falling only at -32768
      if (p == 4) begin hi = -32768; lo = 32767; end
      if (p == 5) begin hi = 32767; lo = -32768; off0 = -10240; off1 = 10240; end
      write_reg(REG_GAINS_G0, {$urandom, $urandom});
      write_reg(REG_GAINS_G1, (p == 5) ? 64'h8000_7FFF_8000_7FFF : {$urandom, $urandom});
      write_reg(REG_AVG_EN, 64'($urandom_range(3)));
      write_reg(REG_OFFSET_G0, 64'(off0));
      write_reg(REG_OFFSET_G1, 64'(off1));
      write_reg(REG_HOLD_HIGH, 64'(hi));
      write_reg(REG_HOLD_LOW, 64'(lo));
      apb_idle();
      // long receiver hold-off while frames keep coming, so the input backs up
      if (p == 4) hold_req++;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_frame(rand_frame(), 1'b0, '0);
    end

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    if (pending_mix.size() != 0) begin
      $error("%0d expected result items never arrived", pending_mix.size());
      n_err++;
    end
    if (n_err == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
design/mgm_pkg.sv
design/mgm_lane.sv
design/mgm_merge.sv
design/mgm_div.sv
design/muted_gain_mixer_with_sample_hold_top.sv
design/mgm_checker.sv
dv/muted_gain_mixer_with_sample_hold_top_tb.sv
